// ----- rtl/fbat_pkg.sv -----
// Shared types, constants and status codes of the flow byte accounting table.
package fbat_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = SLOT_W + 1;
  localparam int OUT_SLOT_W = 7;
  localparam int SLOT_EXT_W = (SLOT_W > OUT_SLOT_W) ? SLOT_W : OUT_SLOT_W;
  localparam int KEY_W = 96;
  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 80;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] MIN_ETH_LEN = 16'd14;
  localparam logic [15:0] MIN_IP_LEN = 16'd34;
  localparam logic [15:0] MIN_TCP_LEN = 16'd54;
  localparam logic [15:0] MIN_UDP_LEN = 16'd42;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic inc_idx;
    logic do_update;
    logic do_insert;
    logic emit_reject;
    logic emit_full;
  } cmd_t;

  typedef struct packed {
    logic rejected;
    logic table_empty;
    logic table_full;
    logic match;
    logic last_idx;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/fbat_ctrl.sv -----
// Controller state machine that sequences classification, search and table update.
module fbat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  fbat_pkg::stat_t stat,
  output fbat_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CMP = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_MISS = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat.rejected) begin
          if (stat.out_free) begin
            cmd.emit_reject = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.table_empty) begin
          state_next = S_MISS;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.match) begin
          state_next = S_UPDATE;
        end else if (stat.last_idx) begin
          state_next = S_MISS;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next = S_READ;
        end
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          cmd.do_update = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat.out_free) begin
          if (stat.table_full) begin
            cmd.emit_full = 1'b1;
          end else begin
            cmd.do_insert = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fbat_datapath.sv -----
// Datapath with request registers, flow table memories, search index and result register.
module fbat_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_direction,
  input  logic [fbat_pkg::IN_DATA_W-1:0]      in_data,
  input  fbat_pkg::cmd_t                      cmd,
  output fbat_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fbat_pkg::OUT_DATA_W-1:0]     out_data
);

  logic        dir;
  logic [15:0] len;
  logic [15:0] etype;
  logic [7:0]  proto;
  logic [31:0] saddr;
  logic [31:0] daddr;
  logic [15:0] sport;
  logic [15:0] dport;

  logic [fbat_pkg::KEY_W-1:0] key_mem [fbat_pkg::TABLE_ENTRIES];
  logic [31:0] sent_mem [fbat_pkg::TABLE_ENTRIES];
  logic [31:0] recv_mem [fbat_pkg::TABLE_ENTRIES];
  logic [fbat_pkg::KEY_W-1:0] key_rd;
  logic [31:0] sent_rd;
  logic [31:0] recv_rd;

  logic [fbat_pkg::SLOT_W-1:0] idx;
  logic [fbat_pkg::CNT_W-1:0]  slots_used;

  logic [2:0]  res_status;
  logic [6:0]  res_slot;
  logic [31:0] res_sent;
  logic [31:0] res_recv;

  logic        is_tcp;
  logic        is_udp;
  logic [15:0] key_sport;
  logic [15:0] key_dport;
  logic [fbat_pkg::KEY_W-1:0] key;
  logic [2:0]  rej_status;
  logic        rejected;
  logic [31:0] len_ext;
  logic [31:0] sent_upd;
  logic [31:0] recv_upd;
  logic        wr_en;
  logic [fbat_pkg::SLOT_W-1:0] wr_addr;
  logic [fbat_pkg::SLOT_W-1:0] ins_addr;
  logic [fbat_pkg::KEY_W-1:0]  wr_key;
  logic [31:0] wr_sent;
  logic [31:0] wr_recv;

  function automatic logic [6:0] slot_out(input logic [fbat_pkg::SLOT_W-1:0] s);
    logic [fbat_pkg::SLOT_EXT_W-1:0] ext;
    ext = fbat_pkg::SLOT_EXT_W'(s);
    return ext[6:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dir   <= in_direction;
      len   <= in_data[15:0];
      etype <= in_data[31:16];
      proto <= in_data[39:32];
      saddr <= in_data[71:40];
      daddr <= in_data[103:72];
      sport <= in_data[119:104];
      dport <= in_data[135:120];
    end
  end

  assign is_tcp = (proto == fbat_pkg::PROTO_TCP);
  assign is_udp = (proto == fbat_pkg::PROTO_UDP);
  assign key_sport = (is_tcp || is_udp) ? sport : 16'd0;
  assign key_dport = (is_tcp || is_udp) ? dport : 16'd0;
  assign key = dir ? {key_dport, key_sport, daddr, saddr}
                   : {key_sport, key_dport, saddr, daddr};

  always_comb begin
    rejected = 1'b1;
    rej_status = fbat_pkg::ST_NOT_IPV4;
    if (len < fbat_pkg::MIN_ETH_LEN || etype != fbat_pkg::ETHERTYPE_IPV4) begin
      rej_status = fbat_pkg::ST_NOT_IPV4;
    end else if (len < fbat_pkg::MIN_IP_LEN || (is_tcp && len < fbat_pkg::MIN_TCP_LEN) ||
                 (is_udp && len < fbat_pkg::MIN_UDP_LEN)) begin
      rej_status = fbat_pkg::ST_SHORT;
    end else begin
      rejected = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (cmd.do_insert) begin
      slots_used <= slots_used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + 1'b1;
    end
  end

  assign len_ext = {16'd0, len};
  assign sent_upd = dir ? sent_rd + len_ext : sent_rd;
  assign recv_upd = dir ? recv_rd : recv_rd + len_ext;
  assign ins_addr = slots_used[fbat_pkg::SLOT_W-1:0];

  assign wr_en   = cmd.do_update || cmd.do_insert;
  assign wr_addr = cmd.do_insert ? ins_addr : idx;
  assign wr_key  = key;
  assign wr_sent = cmd.do_insert ? (dir ? len_ext : 32'd0) : sent_upd;
  assign wr_recv = cmd.do_insert ? (dir ? 32'd0 : len_ext) : recv_upd;

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_en) begin
      sent_mem[wr_addr] <= wr_sent;
      recv_mem[wr_addr] <= wr_recv;
    end
    if (cmd.rd_en) begin
      key_rd  <= key_mem[idx];
      sent_rd <= sent_mem[idx];
      recv_rd <= recv_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_reject || cmd.emit_full || wr_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_reject || cmd.emit_full) begin
      res_status <= cmd.emit_full ? fbat_pkg::ST_FULL : rej_status;
      res_slot   <= '0;
      res_sent   <= '0;
      res_recv   <= '0;
    end else if (wr_en) begin
      res_status <= cmd.do_insert ? fbat_pkg::ST_NEW : fbat_pkg::ST_UPDATED;
      res_slot   <= slot_out(wr_addr);
      res_sent   <= wr_sent;
      res_recv   <= wr_recv;
    end
  end

  assign out_data = {6'd0, res_recv, res_sent, res_slot, res_status};

  assign stat.rejected    = rejected;
  assign stat.table_empty = (slots_used == '0);
  assign stat.table_full  = (slots_used == fbat_pkg::CNT_W'(fbat_pkg::TABLE_ENTRIES));
  assign stat.match       = (key_rd == key);
  assign stat.last_idx    = (({1'b0, idx} + 1'b1) == slots_used);
  assign stat.out_free    = !out_valid || out_ready;

endmodule

// ----- rtl/flow_byte_accounting_table_core.sv -----
// Top level of the IPv4 flow byte accounting table.
// A rejected request gives its result without a table search; other requests run a linear key
// search over the slots in use, reading and then comparing one slot at a time, and give an
// updated, new or table-full result.
// Throughput: one request at a time, the next accepted the cycle after the result is loaded.
// Reset (rst, synchronous) empties the table by clearing the slot count; memories are not cleared.
module flow_byte_accounting_table_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pkt_len, ethertype, ip_protocol, src_addr, dst_addr, src_port, dst_port
  input  logic [135:0] s_tdata,
  // direction
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, slot_index, total_sent, total_received, zero padding
  output logic [79:0]  m_tdata
);

  fbat_pkg::cmd_t  cmd;
  fbat_pkg::stat_t stat;

  fbat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbat_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_direction (s_tuser),
    .in_data      (s_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

endmodule

// ----- rtl/fbat_checker.sv -----
// Port-level checker for the flow byte accounting table, bound to the top level.
module fbat_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed while stalled.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= fbat_pkg::ST_SHORT)
    else $error("Result status out of range.");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == fbat_pkg::ST_FULL || m_tdata[2:0] == fbat_pkg::ST_NOT_IPV4 ||
                 m_tdata[2:0] == fbat_pkg::ST_SHORT) |-> m_tdata[73:3] == '0)
    else $error("Rejected result carries nonzero slot or totals.");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Request accepted while another is in progress.");

endmodule

bind flow_byte_accounting_table_core fbat_checker u_fbat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
